// ===== sv/hsla_pkg.sv =====
package hsla_pkg;

    // Field widths
    localparam int DELAY_W    = 16;
    localparam int NCOL_W     = 11;
    localparam int BRIGHT_W   = 7;
    localparam int LEVEL_W    = 8;
    localparam int STEP_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths (bytes, zero padded)
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * LEVEL_W - STEP_W;

    // Serial divider: dividend covers 255 * (N - r) for N up to 2047
    localparam int DIVD_W    = 19;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int SLICE_W   = 3;

    // Brightness scaling: floor(x / 100) == (x * 5243) >> 19 for x < 43690
    localparam int PROD_W         = LEVEL_W + BRIGHT_W;
    localparam int SCALE_RECIP_W  = 13;
    localparam int SCALE_SHIFT    = 19;
    localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 13'd5243;

    // Reset values and limits
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd20;
    localparam logic [NCOL_W-1:0]   NCOL_RESET   = 11'd256;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 7'd100;
    localparam logic [DELAY_W-1:0]  ELAPSED_MAX  = 16'hFFFF;
    localparam logic [LEVEL_W-1:0]  LEVEL_FULL   = 8'hFF;
    localparam logic [LEVEL_W-1:0]  LEVEL_OFF    = 8'h00;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NCOLORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BRIGHT  = 2'd2;

    // Hue sextants
    localparam logic [SLICE_W-1:0] SEXT_RED_GRN_UP = 3'd0;
    localparam logic [SLICE_W-1:0] SEXT_RED_DOWN   = 3'd1;
    localparam logic [SLICE_W-1:0] SEXT_BLU_UP     = 3'd2;
    localparam logic [SLICE_W-1:0] SEXT_GRN_DOWN   = 3'd3;
    localparam logic [SLICE_W-1:0] SEXT_RED_UP     = 3'd4;
    localparam logic [SLICE_W-1:0] SEXT_BLU_DOWN   = 3'd5;

    typedef enum logic [1:0] {
        DSEL_SLICE = 2'd0,
        DSEL_RISE  = 2'd1,
        DSEL_FALL  = 2'd2
    } div_sel_t;

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_SLICE_GO   = 9'b000000010,
        ST_SLICE_WAIT = 9'b000000100,
        ST_RISE_GO    = 9'b000001000,
        ST_RISE_WAIT  = 9'b000010000,
        ST_FALL_GO    = 9'b000100000,
        ST_FALL_WAIT  = 9'b001000000,
        ST_MUL        = 9'b010000000,
        ST_OUT        = 9'b100000000
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     cfg_we;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_slice;
        logic     cap_rise;
        logic     cap_fall;
        logic     mul_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic div_done;
    } status_t;

endpackage

// ===== sv/hue_spectrum_led_animator.sv =====
// A tick that does not complete a step is taken while idle and gives no beat.
// A tick that completes a step gives its color beat after three passes of a
// one-bit-per-cycle divider by the color count, one brightness multiply and one
// output load, which waits for a free output register; the input stalls meanwhile.
// No new tick is taken until the beat of a stepping tick is loaded; the output register holds a beat.
// Reset (aresetn low, synchronous) restores delay 20, 256 colors, 100 percent.
module hue_spectrum_led_animator
    import hsla_pkg::*;
#(
    parameter int MAX_COLORS = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Tick stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] tick, [7:1] zero

    // Color stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] red_level, [15:8] green_level,
                                                   // [23:16] blue_level,
                                                   // [34:24] step_index, [39:35] zero

    // Register writes: 0 delay ms, 1 color count, 2 brightness percent
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [STEP_W-1:0]  step_index;

    // Controller: sequences the three divisions, scaling and output handoff.
    hsla_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: timer, step counter, hue divider and brightness scaling.
    hsla_dp #(
        .MAX_COLORS (MAX_COLORS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .tick        (s_axis_tdata[0]),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .step_index  (step_index)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, step_index, blue_level, green_level, red_level};

    // A result is only loaded when the output register is free.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output overwritten while a beat is pending");

    // A stepping tick locks out further input while the color is computed.
    a_step_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && status.fire) |=> !s_axis_tready)
        else $error("input accepted during color computation");

    // The divider only finishes while a step is in progress.
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_axis_tready)
        else $error("divider completion while idle");

    // Divider launches never happen in the idle state.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (!s_axis_tready && !cfg_ready))
        else $error("divider started while idle");

endmodule

// ===== sv/hsla_div.sv =====
module hsla_div
    import hsla_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [NCOL_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic [NCOL_W-1:0] remainder,
    output logic              done
);

    // Restoring divider, one quotient bit per cycle.
    logic [DIVD_W-1:0]    quo_reg;
    logic [NCOL_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [NCOL_W:0]   trial;
    logic [NCOL_W:0]   diff;
    logic              fits;
    logic [NCOL_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        diff     = trial - {1'b0, divisor};
        fits     = (trial >= {1'b0, divisor});
        rem_next = fits ? diff[NCOL_W-1:0] : trial[NCOL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== sv/hsla_dp.sv =====
module hsla_dp
    import hsla_pkg::*;
#(
    parameter int MAX_COLORS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  tick,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [LEVEL_W-1:0]    red_level,
    output logic [LEVEL_W-1:0]    green_level,
    output logic [LEVEL_W-1:0]    blue_level,
    output logic [STEP_W-1:0]     step_index
);

    // Config and timing state
    logic [DELAY_W-1:0]  delay_reg;
    logic [NCOL_W-1:0]   ncolors_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [DELAY_W-1:0]  elapsed_reg;
    logic [STEP_W-1:0]   step_reg;

    // Per-step working registers
    logic [STEP_W-1:0]   c_reg;
    logic [NCOL_W-1:0]   k_reg;
    logic [SLICE_W-1:0]  slice_reg;
    logic [NCOL_W-1:0]   r_reg;
    logic [LEVEL_W-1:0]  rise_reg;
    logic [LEVEL_W-1:0]  fall_reg;
    logic [PROD_W-1:0]   red_prod_reg;
    logic [PROD_W-1:0]   green_prod_reg;
    logic [PROD_W-1:0]   blue_prod_reg;
    logic [LEVEL_W-1:0]  red_out_reg;
    logic [LEVEL_W-1:0]  green_out_reg;
    logic [LEVEL_W-1:0]  blue_out_reg;
    logic [STEP_W-1:0]   step_out_reg;

    logic [NCOL_W-1:0]   n_eff;
    logic [BRIGHT_W-1:0] b_eff;
    logic [DELAY_W-1:0]  elapsed_inc;
    logic                fire_due;
    logic                cfg_hit;
    logic [NCOL_W:0]     two_n;
    logic [STEP_W:0]     c_inc;
    logic [STEP_W-1:0]   step_next;
    logic [NCOL_W-1:0]   k_raw;
    logic [NCOL_W-1:0]   k_next;
    logic [NCOL_W-1:0]   n_minus_r;
    logic [DIVD_W-1:0]   dividend;
    logic [LEVEL_W-1:0]  red_val;
    logic [LEVEL_W-1:0]  green_val;
    logic [LEVEL_W-1:0]  blue_val;
    logic [PROD_W+SCALE_RECIP_W-1:0] red_scaled;
    logic [PROD_W+SCALE_RECIP_W-1:0] green_scaled;
    logic [PROD_W+SCALE_RECIP_W-1:0] blue_scaled;
    logic [DIVD_W-1:0]   quotient;
    logic [NCOL_W-1:0]   remainder;
    logic                div_done;

    // Effective color count and brightness
    always_comb begin
        if (ncolors_reg == '0) begin
            n_eff = NCOL_W'(1);
        end else if (32'(ncolors_reg) > 32'(MAX_COLORS)) begin
            n_eff = NCOL_W'(MAX_COLORS);
        end else begin
            n_eff = ncolors_reg;
        end
        b_eff = (bright_reg > BRIGHT_FULL) ? BRIGHT_FULL : bright_reg;
    end

    // Tick timer and step sequencing
    always_comb begin
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                   : elapsed_reg + DELAY_W'(1);
        fire_due    = (elapsed_inc >= delay_reg);
        two_n       = {n_eff, 1'b0};
        c_inc       = {1'b0, step_reg} + (STEP_W + 1)'(1);
        step_next   = (c_inc == two_n) ? '0 : c_inc[STEP_W-1:0];
        k_raw       = (step_reg > n_eff) ? step_reg - n_eff : step_reg;
        k_next      = (k_raw >= n_eff) ? '0 : k_raw;
    end

    assign status.fire     = tick & fire_due;
    assign status.div_done = div_done;

    always_comb begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            CFG_IDX_DELAY:   cfg_hit = 1'b1;
            CFG_IDX_NCOLORS: cfg_hit = 1'b1;
            CFG_IDX_BRIGHT:  cfg_hit = 1'b1;
            default:         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= DELAY_RESET;
            ncolors_reg <= NCOL_RESET;
            bright_reg  <= BRIGHT_RESET;
            elapsed_reg <= '0;
            step_reg    <= '0;
        end else if (cmd.cfg_we && cfg_hit) begin
            unique case (cfg_index)
                CFG_IDX_DELAY:   delay_reg   <= cfg_data[DELAY_W-1:0];
                CFG_IDX_NCOLORS: ncolors_reg <= cfg_data[NCOL_W-1:0];
                CFG_IDX_BRIGHT:  bright_reg  <= cfg_data[BRIGHT_W-1:0];
                default: ;
            endcase
            elapsed_reg <= '0;
            step_reg    <= '0;
        end else if (cmd.accept && tick) begin
            if (fire_due) begin
                elapsed_reg <= '0;
                step_reg    <= step_next;
            end else begin
                elapsed_reg <= elapsed_inc;
            end
        end
    end

    // Divider operand select: 6k, 255r, 255(N-r)
    always_comb begin
        n_minus_r = n_eff - r_reg;
        case (cmd.div_sel)
            DSEL_SLICE: dividend = (DIVD_W'(k_reg) << 2) + (DIVD_W'(k_reg) << 1);
            DSEL_RISE:  dividend = (DIVD_W'(r_reg) << 8) - DIVD_W'(r_reg);
            DSEL_FALL:  dividend = (DIVD_W'(n_minus_r) << 8) - DIVD_W'(n_minus_r);
            default:    dividend = '0;
        endcase
    end

    hsla_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (n_eff),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    // Hue wheel sextant select
    always_comb begin
        red_val   = LEVEL_OFF;
        green_val = LEVEL_OFF;
        blue_val  = LEVEL_OFF;
        case (slice_reg)
            SEXT_RED_GRN_UP: begin
                red_val   = LEVEL_FULL;
                green_val = rise_reg;
            end
            SEXT_RED_DOWN: begin
                red_val   = fall_reg;
                green_val = LEVEL_FULL;
            end
            SEXT_BLU_UP: begin
                green_val = LEVEL_FULL;
                blue_val  = rise_reg;
            end
            SEXT_GRN_DOWN: begin
                green_val = fall_reg;
                blue_val  = LEVEL_FULL;
            end
            SEXT_RED_UP: begin
                red_val  = rise_reg;
                blue_val = LEVEL_FULL;
            end
            SEXT_BLU_DOWN: begin
                red_val  = LEVEL_FULL;
                blue_val = fall_reg;
            end
            default: ;
        endcase
    end

    // Divide by 100 through the reciprocal
    always_comb begin
        red_scaled   = (PROD_W + SCALE_RECIP_W)'(red_prod_reg) * SCALE_RECIP;
        green_scaled = (PROD_W + SCALE_RECIP_W)'(green_prod_reg) * SCALE_RECIP;
        blue_scaled  = (PROD_W + SCALE_RECIP_W)'(blue_prod_reg) * SCALE_RECIP;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && tick && fire_due) begin
            c_reg <= step_reg;
            k_reg <= k_next;
        end
        if (cmd.cap_slice) begin
            slice_reg <= quotient[SLICE_W-1:0];
            r_reg     <= remainder;
        end
        if (cmd.cap_rise) begin
            rise_reg <= quotient[LEVEL_W-1:0];
        end
        if (cmd.cap_fall) begin
            fall_reg <= quotient[LEVEL_W-1:0];
        end
        if (cmd.mul_en) begin
            red_prod_reg   <= PROD_W'(red_val) * PROD_W'(b_eff);
            green_prod_reg <= PROD_W'(green_val) * PROD_W'(b_eff);
            blue_prod_reg  <= PROD_W'(blue_val) * PROD_W'(b_eff);
        end
        if (cmd.out_load) begin
            red_out_reg   <= red_scaled[SCALE_SHIFT +: LEVEL_W];
            green_out_reg <= green_scaled[SCALE_SHIFT +: LEVEL_W];
            blue_out_reg  <= blue_scaled[SCALE_SHIFT +: LEVEL_W];
            step_out_reg  <= c_reg;
        end
    end

    assign red_level   = red_out_reg;
    assign green_level = green_out_reg;
    assign blue_level  = blue_out_reg;
    assign step_index  = step_out_reg;

endmodule

// ===== sv/hsla_ctrl.sv =====
module hsla_ctrl
    import hsla_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    // A register write offered in the same idle cycle goes first; the tick waits.
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DSEL_SLICE;
        cmd.accept    = s_tvalid && s_tready;
        cmd.cfg_we    = cfg_valid && cfg_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && status.fire) begin
                    state_next = ST_SLICE_GO;
                end
            end
            ST_SLICE_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_SLICE;
                state_next    = ST_SLICE_WAIT;
            end
            ST_SLICE_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_slice = 1'b1;
                    state_next    = ST_RISE_GO;
                end
            end
            ST_RISE_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_RISE;
                state_next    = ST_RISE_WAIT;
            end
            ST_RISE_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_rise = 1'b1;
                    state_next   = ST_FALL_GO;
                end
            end
            ST_FALL_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_FALL;
                state_next    = ST_FALL_WAIT;
            end
            ST_FALL_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_fall = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== tb/sv/tb_hue_spectrum_led_animator.sv =====
module tb_hue_spectrum_led_animator;
    import hsla_pkg::*;

    localparam int COLOR_LIMIT     = 1024;   // MAX_COLORS of the instance
    localparam int TICKS_PER_PHASE = 135;    // high ticks per random phase
    localparam int NUM_PHASES      = 12;
    localparam int SETTLE_CYCLES   = 80;     // covers a color pass
    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no beat on any channel

    // Not a register: a write here must leave config and state untouched
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // One color beat as packed in m_axis_tdata, red in the low byte
    typedef struct packed {
        logic [STEP_W-1:0]  step_index;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } color_beat_t;

    // Hue wheel predictor plus the queue of colors still owed by the block
    class hue_step_checker;
        logic [DELAY_W-1:0]  delay_ms;
        logic [NCOL_W-1:0]   ncolors;
        logic [BRIGHT_W-1:0] bright;
        int unsigned         elapsed;
        int unsigned         step_ctr;
        color_beat_t         pending_colors[$];
        int                  errors;

        function new();
            delay_ms = DELAY_RESET;
            ncolors  = NCOL_RESET;
            bright   = BRIGHT_RESET;
            elapsed  = 0;
            step_ctr = 0;
            errors   = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_DELAY:   delay_ms = data[DELAY_W-1:0];
                CFG_IDX_NCOLORS: ncolors  = data[NCOL_W-1:0];
                CFG_IDX_BRIGHT:  bright   = data[BRIGHT_W-1:0];
                default:         return;
            endcase
            elapsed  = 0;
            step_ctr = 0;
        endfunction

        function logic [LEVEL_W-1:0] dim_level(int unsigned v, int unsigned b);
            return LEVEL_W'((v * b) / 100);
        endfunction

        function void note_tick(logic tick);
            int unsigned n, b, c, k, p, r, rise, fall, lvl_r, lvl_g, lvl_b;
            color_beat_t want;
            if (!tick)
                return;
            if (elapsed < ELAPSED_MAX)
                elapsed++;
            if (elapsed < delay_ms)
                return;
            elapsed = 0;

            n = 32'(ncolors);
            if (n == 0)
                n = 1;
            if (n > COLOR_LIMIT)
                n = COLOR_LIMIT;
            b = 32'((bright > BRIGHT_FULL) ? BRIGHT_FULL : bright);

            // forward over the wheel, then forward again; k == N folds to hue 0
            c = step_ctr % (2 * n);
            k = (c > n) ? c - n : c;
            if (k >= n)
                k = 0;
            p    = 6 * k;
            r    = p % n;
            rise = (255 * r) / n;
            fall = (255 * (n - r)) / n;

            lvl_r = 0;
            lvl_g = 0;
            lvl_b = 0;
            case (p / n)
                SEXT_RED_GRN_UP: begin lvl_r = 255;  lvl_g = rise; end
                SEXT_RED_DOWN:   begin lvl_r = fall; lvl_g = 255;  end
                SEXT_BLU_UP:     begin lvl_g = 255;  lvl_b = rise; end
                SEXT_GRN_DOWN:   begin lvl_g = fall; lvl_b = 255;  end
                SEXT_RED_UP:     begin lvl_r = rise; lvl_b = 255;  end
                SEXT_BLU_DOWN:   begin lvl_r = 255;  lvl_b = fall; end
                default: ;
            endcase

            want.red        = dim_level(lvl_r, b);
            want.green      = dim_level(lvl_g, b);
            want.blue       = dim_level(lvl_b, b);
            want.step_index = c[STEP_W-1:0];
            pending_colors.push_back(want);
            step_ctr = (c + 1) % (2 * n);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_color(color_beat_t got);
            color_beat_t want;
            if (pending_colors.size() == 0) begin
                $display("%0t: color beat %h with none expected", $time, got);
                errors++;
                return;
            end
            want = pending_colors.pop_front();
            compare("red_level",   32'(want.red),        32'(got.red));
            compare("green_level", 32'(want.green),      32'(got.green));
            compare("blue_level",  32'(want.blue),       32'(got.blue));
            compare("step_index",  32'(want.step_index), 32'(got.step_index));
        endfunction
    endclass

    // Block inputs start at known values
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] tick, [7:1] zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] red, [15:8] green,
                                                  // [23:16] blue, [34:24] step, [39:35] zero
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    hue_step_checker board = new();

    always #2 aclk = ~aclk;

    hue_spectrum_led_animator #(
        .MAX_COLORS(COLOR_LIMIT)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Receiver: always ready, or ready from a rolling 32-bit stall pattern.
    // The pattern density changes every lap so stall runs vary in length.
    bit          rx_throttle = 1'b0;
    logic [31:0] rx_pattern  = '1;
    logic [4:0]  rx_pos      = '0;

    always @(negedge aclk) begin
        if (!rx_throttle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= rx_pattern[rx_pos];
            rx_pos = rx_pos + 5'd1;
            if (rx_pos == '0) begin
                case ($urandom_range(0, 2))
                    0:       rx_pattern = $urandom & $urandom;
                    1:       rx_pattern = $urandom | $urandom;
                    default: rx_pattern = $urandom;
                endcase
            end
        end
    end

    // Monitor: beats are taken at the rising edge, before the block updates.
    // The color check runs first; a color can never belong to the tick
    // accepted on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_color(m_axis_tdata[3*LEVEL_W+STEP_W-1:0]);
            if (s_axis_tvalid && s_axis_tready)
                board.note_tick(s_axis_tdata[0]);
            if (cfg_valid && cfg_ready)
                board.note_config(cfg_index, cfg_data);
        end
    end

    // Watchdog: any accepted beat on any channel restarts the count
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sender: bursts of random length; in gap phases valid drops between bursts
    bit          tx_gaps    = 1'b0;
    int unsigned burst_left = 0;

    task automatic send_tick(input logic tick);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_gaps) begin
                gap = $urandom_range(1, 12);
                @(negedge aclk) s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, tick};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Hold the sender until every owed color has come out
    task automatic drain_colors();
        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (board.pending_colors.size() != 0)
            @(posedge aclk);
    endtask

    // A non-stepping tick may still be in flight after the last color; wait it out
    task automatic settle();
        drain_colors();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned          phase, sent, first, j;
        logic                 tick;
        logic [CFG_IDX_W-1:0] sel;
        logic [DELAY_W-1:0]   delay_val;
        logic [NCOL_W-1:0]    ncol_val;
        logic [BRIGHT_W-1:0]  bright_val;

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // ---- directed ----
        // reset config (delay 20): a low tick and two high ticks give no color
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        settle();

        // delay 0 steps on every tick; a zero color count acts as one and
        // brightness above full acts as full (bits above each field are dropped)
        write_reg(CFG_IDX_DELAY,   16'd0);
        write_reg(CFG_IDX_NCOLORS, 16'hF800);
        write_reg(CFG_IDX_BRIGHT,  16'hFF7F);
        repeat (3) send_tick(1'b1);
        settle();

        // six colors: one step per sextant, the hue-0 fold at k == N,
        // the second walk over the wheel and the wrap of the step index
        write_reg(CFG_IDX_NCOLORS, 16'd6);
        write_reg(CFG_IDX_BRIGHT,  16'd100);
        repeat (13) send_tick(1'b1);
        settle();

        // largest count, zero brightness, longest delay: ticks give nothing
        write_reg(CFG_IDX_NCOLORS, 16'd2047);
        write_reg(CFG_IDX_BRIGHT,  16'd0);
        write_reg(CFG_IDX_DELAY,   16'hFFFF);
        repeat (3) send_tick(1'b1);
        settle();

        // unused index: config and counters stay as they are
        write_reg(CFG_IDX_UNUSED, 16'h5A5A);

        // ---- random phases ----
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 5))
                0, 5:    delay_val = 16'd0;
                1:       delay_val = 16'd1;
                2, 3:    delay_val = DELAY_W'($urandom_range(2, 4));
                default: delay_val = DELAY_W'($urandom_range(5, 40));
            endcase
            case ($urandom_range(0, 7))
                0:       ncol_val = 11'd1;
                1:       ncol_val = 11'd2;
                2:       ncol_val = 11'd1024;
                3:       ncol_val = NCOL_W'($urandom_range(1025, 2047));
                4:       ncol_val = NCOL_W'($urandom_range(0, 2047));
                default: ncol_val = NCOL_W'($urandom_range(3, 40));
            endcase
            case ($urandom_range(0, 4))
                0:       bright_val = 7'd0;
                1:       bright_val = 7'd100;
                2:       bright_val = BRIGHT_W'($urandom_range(101, 127));
                default: bright_val = BRIGHT_W'($urandom_range(1, 99));
            endcase
            // first phases pin the extremes with colors coming out
            if (phase == 0) begin
                ncol_val   = 11'd1024;
                bright_val = 7'd127;
                delay_val  = 16'd0;
            end else if (phase == 1) begin
                ncol_val   = 11'd2047;
                bright_val = 7'd0;
                delay_val  = 16'd1;
            end else if (phase == 2) begin
                ncol_val   = 11'd1;
                bright_val = 7'd100;
            end

            // all three registers, in rotating order; junk above the color count and brightness fields
            first = $urandom_range(0, 2);
            for (j = 0; j < 3; j++) begin
                sel = CFG_IDX_W'((first + j) % 3);
                case (sel)
                    CFG_IDX_DELAY:   write_reg(CFG_IDX_DELAY, delay_val);
                    CFG_IDX_NCOLORS: write_reg(CFG_IDX_NCOLORS,
                                               {5'($urandom), ncol_val});
                    default:         write_reg(CFG_IDX_BRIGHT,
                                               {9'($urandom), bright_val});
                endcase
            end

            tx_gaps     = (phase > 0) && ($urandom_range(0, 3) != 0);
            rx_throttle = (phase > 0) && ($urandom_range(0, 3) != 0);
            burst_left  = 0;

            sent = 0;
            while (sent < TICKS_PER_PHASE) begin
                tick = ($urandom_range(0, 9) != 0);
                send_tick(tick);
                if (tick)
                    sent++;
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 299) == 0)
                    drain_colors();
            end
        end

        drain_colors();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hsla_pkg.sv
sv/hsla_div.sv
sv/hsla_dp.sv
sv/hsla_ctrl.sv
sv/hue_spectrum_led_animator.sv
tb/sv/tb_hue_spectrum_led_animator.sv
